// ----- design/scfp_pkg.sv -----
package scfp_pkg;

   // Frame geometry.
   localparam int LONG_PAYLOAD  = 32;
   localparam int SHORT_PAYLOAD = 8;
   localparam int HEADER_LEN    = 3;

   // Derived widths.
   localparam int IDX_W = $clog2(LONG_PAYLOAD);
   localparam int POS_W = $clog2(HEADER_LEN + LONG_PAYLOAD);

   // Payload memory holds one frame per bank; the queue tracks one frame per bank.
   localparam int BANK_COUNT  = 2;
   localparam int BANK_W      = $clog2(BANK_COUNT);
   localparam int RAM_DEPTH   = BANK_COUNT * LONG_PAYLOAD;
   localparam int QUEUE_DEPTH = BANK_COUNT;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths fixed by the interface.
   localparam int BYTE_W     = 8;
   localparam int TIME_W     = 32;
   localparam int INDEX_F_W  = 5;
   localparam int LENGTH_F_W = 6;
   localparam int GAP_W      = 16;
   localparam int OFFSET_W   = 3;
   localparam int CSR_DATA_W = 16;

   // Header byte values and the short-frame command threshold.
   localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hFE;
   localparam logic [BYTE_W-1:0] SECOND_BYTE   = 8'h1C;
   localparam logic [BYTE_W-1:0] SHORT_CMD_MIN = 8'h80;

   // Frame positions of the header bytes.
   localparam logic [POS_W-1:0] POS_IDLE     = POS_W'(0);
   localparam logic [POS_W-1:0] POS_SYNC     = POS_W'(1);
   localparam logic [POS_W-1:0] POS_CHECKSUM = POS_W'(2);

   // Configuration reset values.
   localparam logic [GAP_W-1:0]    GAP_TIMEOUT_RESET = 16'd100;
   localparam logic [OFFSET_W-1:0] CMD_OFFSET_RESET  = 3'd0;

   // Result status codes.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [0:0] {
      CSR_GAP_TIMEOUT = 1'b0,
      CSR_CMD_OFFSET  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic [BYTE_W-1:0]     payload_byte;
      logic [INDEX_F_W-1:0]  byte_index;
      logic [LENGTH_F_W-1:0] frame_length;
      logic                  last;
   } rsp_type;

   // One finished frame handed from the front end to the back end.
   typedef struct packed {
      logic [BANK_W-1:0] bank;
      logic              is_long;
      logic              sum_ok;
   } frame_desc_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_READ,
      BACK_LOAD
   } back_state_type;

endpackage

// ----- design/scfp_ram.sv -----
module scfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/scfp_front.sv -----
module scfp_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  scfp_pkg::req_type                      req_payload,
   input  logic                                   csr_we,
   input  scfp_pkg::csr_index_type                csr_index,
   input  logic [scfp_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  logic                                   q_full,
   output logic                                   push,
   output scfp_pkg::frame_desc_type               push_desc,
   output logic                                   ram_we,
   output logic [scfp_pkg::BANK_W+scfp_pkg::IDX_W-1:0] ram_waddr,
   output logic [scfp_pkg::BYTE_W-1:0]            ram_wdata
);
   import scfp_pkg::*;

   logic [GAP_W-1:0]    gap_timeout_ff, gap_timeout_in;
   logic [OFFSET_W-1:0] cmd_offset_ff, cmd_offset_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [BYTE_W-1:0]   expected_ff, expected_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [TIME_W-1:0]   last_time_ff, last_time_in;
   logic                cmd_ff, cmd_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;

   logic                accept;
   logic [TIME_W-1:0]   gap;
   logic                timed_out;
   logic [POS_W-1:0]    pos_eff;
   logic [IDX_W-1:0]    idx;
   logic [BYTE_W-1:0]   sum_next;
   logic                at_cmd;
   logic                cmd_now;
   logic                short_done;
   logic                long_done;

   // A new word can be taken whenever a payload bank is free.
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Configuration registers take writes directly.
   always_comb begin
      gap_timeout_in = gap_timeout_ff;
      cmd_offset_in  = cmd_offset_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_GAP_TIMEOUT: gap_timeout_in = GAP_W'(csr_wdata);
            CSR_CMD_OFFSET:  cmd_offset_in  = OFFSET_W'(csr_wdata);
         endcase
      end
   end

   // Gap check, payload index and short-frame decision for the incoming word.
   always_comb begin
      gap        = req_payload.now_ms - last_time_ff;
      timed_out  = gap > TIME_W'(gap_timeout_ff);
      pos_eff    = timed_out ? POS_IDLE : pos_ff;
      idx        = IDX_W'(pos_eff - POS_W'(HEADER_LEN));
      sum_next   = sum_ff + req_payload.rx_byte;
      at_cmd     = idx == IDX_W'(cmd_offset_ff);
      cmd_now    = at_cmd ? (req_payload.rx_byte >= SHORT_CMD_MIN) : cmd_ff;
      short_done = (idx == IDX_W'(SHORT_PAYLOAD - 1)) &&
                   (int'(cmd_offset_ff) < SHORT_PAYLOAD) && cmd_now;
      long_done  = idx == IDX_W'(LONG_PAYLOAD - 1);
   end

   // Framing: header tracking, payload store, checksum and frame hand-off.
   always_comb begin
      pos_in       = pos_ff;
      expected_in  = expected_ff;
      sum_in       = sum_ff;
      last_time_in = last_time_ff;
      cmd_in       = cmd_ff;
      bank_in      = bank_ff;
      push         = 1'b0;
      push_desc    = '{bank: bank_ff, is_long: !short_done, sum_ok: sum_next == expected_ff};
      ram_we       = 1'b0;
      ram_waddr    = {bank_ff, idx};
      ram_wdata    = req_payload.rx_byte;
      if (accept) begin
         last_time_in = req_payload.now_ms;
         unique case (pos_eff)
            POS_IDLE: begin
               pos_in = (req_payload.rx_byte == SYNC_BYTE) ? POS_SYNC : POS_IDLE;
            end
            POS_SYNC: begin
               if (req_payload.rx_byte == SECOND_BYTE) begin
                  pos_in = POS_CHECKSUM;
               end else if (req_payload.rx_byte == SYNC_BYTE) begin
                  pos_in = POS_SYNC;
               end else begin
                  pos_in = POS_IDLE;
               end
            end
            POS_CHECKSUM: begin
               expected_in = req_payload.rx_byte;
               sum_in      = '0;
               pos_in      = POS_W'(HEADER_LEN);
            end
            default: begin
               ram_we = 1'b1;
               sum_in = sum_next;
               if (at_cmd) begin
                  cmd_in = cmd_now;
               end
               if (short_done || long_done) begin
                  push    = 1'b1;
                  pos_in  = POS_IDLE;
                  bank_in = BANK_W'(bank_ff + 1'b1);
               end else begin
                  pos_in = POS_W'(pos_eff + 1'b1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_timeout_ff <= GAP_TIMEOUT_RESET;
         cmd_offset_ff  <= CMD_OFFSET_RESET;
         pos_ff         <= POS_IDLE;
         expected_ff    <= '0;
         sum_ff         <= '0;
         last_time_ff   <= '0;
         cmd_ff         <= 1'b0;
         bank_ff        <= '0;
      end else begin
         gap_timeout_ff <= gap_timeout_in;
         cmd_offset_ff  <= cmd_offset_in;
         pos_ff         <= pos_in;
         expected_ff    <= expected_in;
         sum_ff         <= sum_in;
         last_time_ff   <= last_time_in;
         cmd_ff         <= cmd_in;
         bank_ff        <= bank_in;
      end
   end

   // The frame position never runs past the last payload byte.
   assert property (@(posedge clock) disable iff (reset)
      int'(pos_ff) < HEADER_LEN + LONG_PAYLOAD)
      else $error("frame position out of range");

   // A frame is handed off only when the queue has room for it.
   assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("frame handed off while queue full");

endmodule

// ----- design/scfp_queue.sv -----
module scfp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  scfp_pkg::frame_desc_type  push_desc,
   input  logic                      pop,
   output scfp_pkg::frame_desc_type  head_desc,
   output logic                      empty,
   output logic                      full
);
   import scfp_pkg::*;

   frame_desc_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign empty     = count_ff == '0;
   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_desc = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_ff + 1'b1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_ff + 1'b1);
      end
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // The back end never retires a frame that is not there.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue popped while empty");

endmodule

// ----- design/scfp_back.sv -----
module scfp_back (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_empty,
   input  scfp_pkg::frame_desc_type               head_desc,
   output logic                                   pop,
   output logic                                   ram_re,
   output logic [scfp_pkg::BANK_W+scfp_pkg::IDX_W-1:0] ram_raddr,
   input  logic [scfp_pkg::BYTE_W-1:0]            ram_rdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output scfp_pkg::rsp_type                      rsp_payload
);
   import scfp_pkg::*;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic                  out_free;
   logic [LENGTH_F_W-1:0] frame_len;
   logic [IDX_W-1:0]      last_idx;
   logic                  is_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign frame_len = head_desc.is_long ? LENGTH_F_W'(LONG_PAYLOAD) : LENGTH_F_W'(SHORT_PAYLOAD);
   assign last_idx  = head_desc.is_long ? IDX_W'(LONG_PAYLOAD - 1) : IDX_W'(SHORT_PAYLOAD - 1);
   assign is_last   = i_ff == last_idx;
   assign ram_raddr = {head_desc.bank, i_ff};

   // Drain sequencer: one error word, or one read and one output load per payload byte.
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pop          = 1'b0;
      ram_re       = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               if (!head_desc.sum_ok) begin
                  if (out_free) begin
                     rsp_in       = '{status: STATUS_ERROR, payload_byte: '0, byte_index: '0,
                                      frame_length: frame_len, last: 1'b1};
                     rsp_valid_in = 1'b1;
                     pop          = 1'b1;
                  end
               end else begin
                  i_in     = '0;
                  state_in = BACK_READ;
               end
            end
         end
         BACK_READ: begin
            ram_re   = 1'b1;
            state_in = BACK_LOAD;
         end
         BACK_LOAD: begin
            if (out_free) begin
               rsp_in       = '{status: STATUS_OK, payload_byte: ram_rdata,
                                byte_index: INDEX_F_W'(i_ff), frame_length: frame_len,
                                last: is_last};
               rsp_valid_in = 1'b1;
               if (is_last) begin
                  pop      = 1'b1;
                  state_in = BACK_IDLE;
               end else begin
                  i_in     = IDX_W'(i_ff + 1'b1);
                  state_in = BACK_READ;
               end
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output word register needs no reset.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The drain runs only while its frame is still held in the queue.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != BACK_IDLE) |-> !q_empty)
      else $error("drain running without a queued frame");

   // An error word is the only and final word of its frame.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_ERROR) |->
         (rsp_ff.last && rsp_ff.byte_index == '0 && rsp_ff.payload_byte == '0))
      else $error("malformed error word");

endmodule

// ----- design/serial_command_frame_parser.sv -----
// Channel   Direction  Handshake              Word
// req_      in         req_valid/req_ready    rx_byte, now_ms
// rsp_      out        rsp_valid/rsp_ready    status, payload_byte, byte_index,
//                                             frame_length, last
// csr_      in         csr_we                 csr_index, csr_wdata
//
// The front end takes one received byte per cycle while one of the two payload banks is free.
// The back end reads each payload byte from the payload RAM through its registered read port
// (BACK_READ), then loads it as an output word (BACK_LOAD); a bad frame drains as one error word.
// Reset is synchronous and clears all control state; the payload RAM is not cleared.
// A stalled result stream stops the drain; the front end keeps taking bytes into the other bank.
module serial_command_frame_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scfp_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scfp_pkg::rsp_type               rsp_payload,
   input  logic                            csr_we,
   input  scfp_pkg::csr_index_type         csr_index,
   input  logic [scfp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import scfp_pkg::*;

   logic                      push;
   frame_desc_type            push_desc;
   logic                      pop;
   frame_desc_type            head_desc;
   logic                      q_empty;
   logic                      q_full;
   logic                      ram_we;
   logic [BANK_W+IDX_W-1:0]   ram_waddr;
   logic [BYTE_W-1:0]         ram_wdata;
   logic                      ram_re;
   logic [BANK_W+IDX_W-1:0]   ram_raddr;
   logic [BYTE_W-1:0]         ram_rdata;

   // Framing, checksum and payload capture.
   scfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .push        (push),
      .push_desc   (push_desc),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   // Two-bank payload storage.
   scfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Finished frames waiting to be drained.
   scfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .empty     (q_empty),
      .full      (q_full)
   );

   // Result drain.
   scfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .head_desc   (head_desc),
      .pop         (pop),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
